### rtl/core/jddm_pkg.sv
package jddm_pkg;

    localparam int ADC_BITS_DEF = 12;

    localparam int RAW_W  = 12;
    localparam int FS_W   = 13;
    localparam int DZ_W   = 11;
    localparam int HALF_W = FS_W - 1;
    localparam int AXIS_W = 12;
    localparam int MAG_W  = 11;
    localparam int SPD_W  = 8;
    localparam int ANG_W  = 9;
    localparam int DRV_W  = 9;
    localparam int FAC_W  = 7;

    localparam logic [FS_W-1:0]  FS_RESET = 13'd1024;
    localparam logic [DZ_W-1:0]  DZ_RESET = 11'd50;
    localparam logic [MAG_W-1:0] LIM_MAX  = 11'd2047;

    localparam int CORDIC_STEPS     = 20;
    localparam int CORDIC_PER_STAGE = 2;
    localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam int CORDIC_FRAC      = 20;
    localparam int CORDIC_W         = 34;
    localparam int Z_W              = 24;
    localparam int Z_FRAC           = 16;
    localparam logic signed [Z_W-1:0] Z_MAX   = 24'sd5898240;
    localparam logic signed [Z_W-1:0] Z_ROUND = 24'sd65535;

    localparam int DIV_BITS = 8;
    localparam int NUM_W    = MAG_W + DIV_BITS;

    localparam logic [7:0] DEG_45  = 8'd45;
    localparam logic [7:0] DEG_90  = 8'd90;
    localparam logic [7:0] DEG_180 = 8'd180;

    localparam int PROD_W      = SPD_W + FAC_W;
    localparam int RECIP_SHIFT = 21;
    localparam logic [PROD_W-1:0] RECIP_90 = 15'd23302;

    typedef enum logic {
        CFG_FULL_SCALE = 1'b0,
        CFG_DEAD_ZONE  = 1'b1
    } t_cfg_idx;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
        case (idx)
            5'd0:    return 24'sd2949120;
            5'd1:    return 24'sd1740967;
            5'd2:    return 24'sd919879;
            5'd3:    return 24'sd466945;
            5'd4:    return 24'sd234379;
            5'd5:    return 24'sd117304;
            5'd6:    return 24'sd58666;
            5'd7:    return 24'sd29335;
            5'd8:    return 24'sd14668;
            5'd9:    return 24'sd7334;
            5'd10:   return 24'sd3667;
            5'd11:   return 24'sd1833;
            5'd12:   return 24'sd917;
            5'd13:   return 24'sd458;
            5'd14:   return 24'sd229;
            5'd15:   return 24'sd115;
            5'd16:   return 24'sd57;
            5'd17:   return 24'sd29;
            5'd18:   return 24'sd14;
            5'd19:   return 24'sd7;
            default: return 24'sd0;
        endcase
    endfunction

    function automatic logic signed [CORDIC_W-1:0] shr_signed(
        input logic signed [CORDIC_W-1:0] v,
        input logic [4:0]                 s
    );
        logic [CORDIC_W-1:0] m;
        m = v[CORDIC_W-1] ? $unsigned(-v) : $unsigned(v);
        m = m >> s;
        return v[CORDIC_W-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

### rtl/core/joystick_differential_drive_mixer.sv
// Joystick mixer: a sample pair is taken on any clock edge with start high and busy low
// (busy is high during reset and for the first cycle after it), one pair per cycle with no
// gaps. Each pair yields one result, shown for a single cycle with o_valid high; it passes
// stages A and B, the ten-stage CORDIC angle pipeline, which runs beside the bit-per-stage
// speed divider, then stages Z, F, M1, M2 and the output register. The receiver cannot stall
// the results. Write full_scale and dead_zone only while no transaction is in flight.
module joystick_differential_drive_mixer #(
    parameter int ADC_BITS = jddm_pkg::ADC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [jddm_pkg::FS_W-1:0]           i_cfg_data,
    input  logic [jddm_pkg::RAW_W-1:0]          i_raw_forward,
    input  logic [jddm_pkg::RAW_W-1:0]          i_raw_turn,
    output logic                                o_valid,
    output logic signed [jddm_pkg::AXIS_W-1:0]  o_centered_forward,
    output logic signed [jddm_pkg::AXIS_W-1:0]  o_centered_turn,
    output logic [jddm_pkg::SPD_W-1:0]          o_speed_code,
    output logic signed [jddm_pkg::ANG_W-1:0]   o_angle_deg,
    output logic signed [jddm_pkg::DRV_W-1:0]   o_right_drive,
    output logic signed [jddm_pkg::DRV_W-1:0]   o_left_drive
);

    localparam int AW  = jddm_pkg::AXIS_W;
    localparam int MW  = jddm_pkg::MAG_W;
    localparam int HW  = jddm_pkg::HALF_W;
    localparam int SW  = jddm_pkg::SPD_W;
    localparam int GW  = jddm_pkg::ANG_W;
    localparam int FW  = jddm_pkg::FAC_W;
    localparam int PW  = jddm_pkg::PROD_W;
    localparam int NW  = jddm_pkg::NUM_W;
    localparam int ZW  = jddm_pkg::Z_W;
    localparam int ST  = jddm_pkg::CORDIC_STAGES;
    localparam int DB  = jddm_pkg::DIV_BITS;
    localparam int RW  = jddm_pkg::RAW_W;
    localparam logic [RW-1:0] RAW_MASK =
        (ADC_BITS >= RW) ? {RW{1'b1}} : RW'((1 << ADC_BITS) - 1);

    logic                          r_busy;
    logic [jddm_pkg::FS_W-1:0]     r_full_scale;
    logic [jddm_pkg::DZ_W-1:0]     r_dead_zone;
    logic                          accept;

    logic [HW-1:0]                 half;
    logic [MW-1:0]                 lim;
    logic                          div_pos;
    logic [MW-1:0]                 div_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_full_scale <= jddm_pkg::FS_RESET;
            r_dead_zone  <= jddm_pkg::DZ_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == jddm_pkg::CFG_FULL_SCALE) begin
                    r_full_scale <= i_cfg_data;
                end else begin
                    r_dead_zone <= i_cfg_data[jddm_pkg::DZ_W-1:0];
                end
            end
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    always_comb begin
        half = r_full_scale[jddm_pkg::FS_W-1:1];
        if (half == '0) begin
            lim = '0;
        end else if ((half - 1'b1) > HW'(jddm_pkg::LIM_MAX)) begin
            lim = jddm_pkg::LIM_MAX;
        end else begin
            lim = MW'(half - 1'b1);
        end
        div_pos = lim > r_dead_zone;
        div_mag = lim - r_dead_zone;
    end

    function automatic logic signed [AW-1:0] center(
        input logic [RW-1:0] raw,
        input logic [HW-1:0] h,
        input logic [MW-1:0] l
    );
        logic signed [AW+1:0] d, lp, ln;
        d  = $signed({2'b00, raw & RAW_MASK}) - $signed({2'b00, h});
        lp = $signed({3'b000, l});
        ln = -lp;
        if (d > lp) begin
            d = lp;
        end else if (d < ln) begin
            d = ln;
        end
        return d[AW-1:0];
    endfunction

    // stage A: center and clamp
    logic                 r_a_vld;
    logic signed [AW-1:0] r_a_f, r_a_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
        end
        r_a_f <= center(i_raw_forward, half, lim);
        r_a_t <= center(i_raw_turn, half, lim);
    end

    // stage B: radius and dead zone
    logic                 r_b_vld, r_b_en, r_b_fneg, r_b_tneg;
    logic signed [AW-1:0] r_b_f, r_b_t;
    logic [MW-1:0]        r_b_xm, r_b_ym, r_b_num;
    logic [MW-1:0]        af, at, radius;
    logic                 in_dz;

    always_comb begin
        af     = r_a_f[AW-1] ? MW'(-r_a_f) : MW'(r_a_f);
        at     = r_a_t[AW-1] ? MW'(-r_a_t) : MW'(r_a_t);
        radius = (af > at) ? af : at;
        in_dz  = radius < r_dead_zone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_f    <= in_dz ? '0 : r_a_f;
        r_b_t    <= in_dz ? '0 : r_a_t;
        r_b_xm   <= in_dz ? '0 : at;
        r_b_ym   <= in_dz ? '0 : af;
        r_b_fneg <= !in_dz && r_a_f[AW-1];
        r_b_tneg <= !in_dz && r_a_t[AW-1];
        r_b_en   <= !in_dz && div_pos;
        r_b_num  <= radius - r_dead_zone;
    end

    // stages C: angle in the CORDIC, speed divider and sideband alongside
    logic signed [ZW-1:0] cordic_z;

    jddm_cordic u_cordic (
        .i_clk (i_clk),
        .i_xm  (r_b_xm),
        .i_ym  (r_b_ym),
        .o_z   (cordic_z)
    );

    logic                 r_c_vld  [ST];
    logic                 r_c_en   [ST];
    logic                 r_c_fneg [ST];
    logic                 r_c_tneg [ST];
    logic signed [AW-1:0] r_c_f    [ST];
    logic signed [AW-1:0] r_c_t    [ST];
    logic [MW-1:0]        r_c_xm   [ST];
    logic [MW-1:0]        r_c_ym   [ST];
    logic [NW-1:0]        r_c_rem  [ST];
    logic [SW-1:0]        r_c_q    [ST];

    for (genvar s = 0; s < ST; s++) begin : g_div
        logic [NW-1:0] n_rem;
        logic [SW-1:0] n_q;

        if (s == 0) begin : g_mul
            assign n_rem = {r_b_num, {DB{1'b0}}} - NW'(r_b_num);
            assign n_q   = '0;
        end else if (s <= DB) begin : g_bit
            localparam int B = DB - s;
            logic [NW-1:0] sub;
            always_comb begin
                sub   = NW'(div_mag) << B;
                n_rem = r_c_rem[s-1];
                n_q   = r_c_q[s-1];
                if (r_c_rem[s-1] >= sub) begin
                    n_rem  = r_c_rem[s-1] - sub;
                    n_q[B] = 1'b1;
                end
            end
        end else begin : g_hold
            assign n_rem = r_c_rem[s-1];
            assign n_q   = r_c_q[s-1];
        end

        if (s == 0) begin : g_in
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_c_vld[s] <= 1'b0;
                end else begin
                    r_c_vld[s] <= r_b_vld;
                end
                r_c_en[s]   <= r_b_en;
                r_c_fneg[s] <= r_b_fneg;
                r_c_tneg[s] <= r_b_tneg;
                r_c_f[s]    <= r_b_f;
                r_c_t[s]    <= r_b_t;
                r_c_xm[s]   <= r_b_xm;
                r_c_ym[s]   <= r_b_ym;
                r_c_rem[s]  <= n_rem;
                r_c_q[s]    <= n_q;
            end
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_c_vld[s] <= 1'b0;
                end else begin
                    r_c_vld[s] <= r_c_vld[s-1];
                end
                r_c_en[s]   <= r_c_en[s-1];
                r_c_fneg[s] <= r_c_fneg[s-1];
                r_c_tneg[s] <= r_c_tneg[s-1];
                r_c_f[s]    <= r_c_f[s-1];
                r_c_t[s]    <= r_c_t[s-1];
                r_c_xm[s]   <= r_c_xm[s-1];
                r_c_ym[s]   <= r_c_ym[s-1];
                r_c_rem[s]  <= n_rem;
                r_c_q[s]    <= n_q;
            end
        end
    end

    // stage Z: angle in whole degrees
    logic signed [ZW-1:0] zc, zr;
    logic [7:0]           lo, hi, mag;
    logic signed [GW-1:0] n_ang;

    always_comb begin
        zc = cordic_z;
        if (zc < 0) begin
            zc = '0;
        end else if (zc > jddm_pkg::Z_MAX) begin
            zc = jddm_pkg::Z_MAX;
        end
        zr = zc + jddm_pkg::Z_ROUND;
        lo = {1'b0, zc[jddm_pkg::Z_FRAC +: FW]};
        hi = {1'b0, zr[jddm_pkg::Z_FRAC +: FW]};
        if (r_c_ym[ST-1] == '0) begin
            lo = '0;
            hi = '0;
        end else if (r_c_xm[ST-1] == '0) begin
            lo = jddm_pkg::DEG_90;
            hi = jddm_pkg::DEG_90;
        end else if (r_c_xm[ST-1] == r_c_ym[ST-1]) begin
            lo = jddm_pkg::DEG_45;
            hi = jddm_pkg::DEG_45;
        end
        mag   = r_c_tneg[ST-1] ? (jddm_pkg::DEG_180 - hi) : lo;
        n_ang = r_c_fneg[ST-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    logic                 r_z_vld;
    logic signed [GW-1:0] r_z_ang;
    logic [SW-1:0]        r_z_spd;
    logic signed [AW-1:0] r_z_f, r_z_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_vld <= 1'b0;
        end else begin
            r_z_vld <= r_c_vld[ST-1];
        end
        r_z_ang <= n_ang;
        r_z_spd <= r_c_en[ST-1] ? r_c_q[ST-1] : '0;
        r_z_f   <= r_c_f[ST-1];
        r_z_t   <= r_c_t[ST-1];
    end

    // stage F: per-quadrant scale factors
    logic [FW-1:0]        n_fr, n_fl;
    logic                 n_neg;
    logic signed [GW-1:0] tmp;

    always_comb begin
        n_neg = r_z_ang[GW-1];
        tmp   = '0;
        if (!n_neg) begin
            if (r_z_ang > $signed({1'b0, jddm_pkg::DEG_90})) begin
                n_fr = FW'(jddm_pkg::DEG_90);
                tmp  = $signed({1'b0, jddm_pkg::DEG_180}) - r_z_ang;
                n_fl = tmp[FW-1:0];
            end else begin
                n_fr = r_z_ang[FW-1:0];
                n_fl = FW'(jddm_pkg::DEG_90);
            end
        end else begin
            if (r_z_ang <= -$signed({1'b0, jddm_pkg::DEG_90})) begin
                n_fr = FW'(jddm_pkg::DEG_90);
                tmp  = r_z_ang + $signed({1'b0, jddm_pkg::DEG_180});
                n_fl = tmp[FW-1:0];
            end else begin
                tmp  = -r_z_ang;
                n_fr = tmp[FW-1:0];
                n_fl = FW'(jddm_pkg::DEG_90);
            end
        end
    end

    logic                 r_f_vld, r_f_neg;
    logic [FW-1:0]        r_f_fr, r_f_fl;
    logic signed [GW-1:0] r_f_ang;
    logic [SW-1:0]        r_f_spd;
    logic signed [AW-1:0] r_f_f, r_f_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_z_vld;
        end
        r_f_neg <= n_neg;
        r_f_fr  <= n_fr;
        r_f_fl  <= n_fl;
        r_f_ang <= r_z_ang;
        r_f_spd <= r_z_spd;
        r_f_f   <= r_z_f;
        r_f_t   <= r_z_t;
    end

    // stage M1: speed times factor
    logic                 r_m_vld, r_m_neg;
    logic [PW-1:0]        r_m_pr, r_m_pl;
    logic signed [GW-1:0] r_m_ang;
    logic [SW-1:0]        r_m_spd;
    logic signed [AW-1:0] r_m_f, r_m_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_f_vld;
        end
        r_m_neg <= r_f_neg;
        r_m_pr  <= PW'(r_f_spd) * PW'(r_f_fr);
        r_m_pl  <= PW'(r_f_spd) * PW'(r_f_fl);
        r_m_ang <= r_f_ang;
        r_m_spd <= r_f_spd;
        r_m_f   <= r_f_f;
        r_m_t   <= r_f_t;
    end

    // stage M2: divide by 90 through the reciprocal
    logic                 r_n_vld, r_n_neg;
    logic [2*PW-1:0]      r_n_qr, r_n_ql;
    logic signed [GW-1:0] r_n_ang;
    logic [SW-1:0]        r_n_spd;
    logic signed [AW-1:0] r_n_f, r_n_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else begin
            r_n_vld <= r_m_vld;
        end
        r_n_neg <= r_m_neg;
        r_n_qr  <= r_m_pr * jddm_pkg::RECIP_90;
        r_n_ql  <= r_m_pl * jddm_pkg::RECIP_90;
        r_n_ang <= r_m_ang;
        r_n_spd <= r_m_spd;
        r_n_f   <= r_m_f;
        r_n_t   <= r_m_t;
    end

    // output stage
    logic signed [jddm_pkg::DRV_W-1:0] qr_s, ql_s;

    assign qr_s = $signed({1'b0, r_n_qr[jddm_pkg::RECIP_SHIFT +: SW]});
    assign ql_s = $signed({1'b0, r_n_ql[jddm_pkg::RECIP_SHIFT +: SW]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_n_vld;
        end
        o_centered_forward <= r_n_f;
        o_centered_turn    <= r_n_t;
        o_speed_code       <= r_n_spd;
        o_angle_deg        <= r_n_ang;
        o_right_drive      <= r_n_neg ? -qr_s : qr_s;
        o_left_drive       <= r_n_neg ? -ql_s : ql_s;
    end

    a_left_full_in_first_quadrant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_angle_deg >= 0 && o_angle_deg <= 9'sd90
        |-> o_left_drive == $signed({1'b0, o_speed_code}))
        else $error("left drive differs from speed in first quadrant");

    a_right_full_in_second_quadrant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_angle_deg > 9'sd90
        |-> o_right_drive == $signed({1'b0, o_speed_code}))
        else $error("right drive differs from speed in second quadrant");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_angle_deg >= -9'sd179 && o_angle_deg <= 9'sd180)
        else $error("angle out of range");

    a_centered_is_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_centered_forward == 0 && o_centered_turn == 0
        |-> o_angle_deg == 0 && o_speed_code == 0 && o_right_drive == 0 && o_left_drive == 0)
        else $error("centered stick gives motion");

endmodule

### rtl/core/jddm_cordic.sv
module jddm_cordic (
    input  logic                               i_clk,
    input  logic [jddm_pkg::MAG_W-1:0]         i_xm,
    input  logic [jddm_pkg::MAG_W-1:0]         i_ym,
    output logic signed [jddm_pkg::Z_W-1:0]    o_z
);

    localparam int STAGES = jddm_pkg::CORDIC_STAGES;
    localparam int PER    = jddm_pkg::CORDIC_PER_STAGE;
    localparam int W      = jddm_pkg::CORDIC_W;
    localparam int ZW     = jddm_pkg::Z_W;
    localparam int PAD    = W - jddm_pkg::MAG_W - jddm_pkg::CORDIC_FRAC;

    logic signed [W-1:0]  r_x [STAGES];
    logic signed [W-1:0]  r_y [STAGES];
    logic signed [ZW-1:0] r_z [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic signed [W-1:0]  x_in, y_in, n_x, n_y;
        logic signed [ZW-1:0] z_in, n_z;

        if (s == 0) begin : g_first
            assign x_in = $signed({{PAD{1'b0}}, i_xm, {jddm_pkg::CORDIC_FRAC{1'b0}}});
            assign y_in = $signed({{PAD{1'b0}}, i_ym, {jddm_pkg::CORDIC_FRAC{1'b0}}});
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_x[s-1];
            assign y_in = r_y[s-1];
            assign z_in = r_z[s-1];
        end

        always_comb begin
            logic signed [W-1:0]  x, y, dx, dy;
            logic signed [ZW-1:0] z;
            logic [4:0]           k;
            x = x_in;
            y = y_in;
            z = z_in;
            for (int j = 0; j < PER; j++) begin
                k  = 5'(s * PER + j);
                dx = jddm_pkg::shr_signed(y, k);
                dy = jddm_pkg::shr_signed(x, k);
                if (y > 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + jddm_pkg::atan_q16(k);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - jddm_pkg::atan_q16(k);
                end
            end
            n_x = x;
            n_y = y;
            n_z = z;
        end

        always_ff @(posedge i_clk) begin
            r_x[s] <= n_x;
            r_y[s] <= n_y;
            r_z[s] <= n_z;
        end
    end

    assign o_z = r_z[STAGES-1];

endmodule
